// ----- src/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// Types and constants shared by the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int VOICES       = 16;
  localparam int SAMPLE_DEPTH = 8192;
  localparam int SEGS         = 3;
  localparam int VW           = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW           = $clog2(SAMPLE_DEPTH);
  localparam int LW           = AW + 1;
  localparam int MEM_DEPTH    = VOICES * SEGS * SAMPLE_DEPTH;
  localparam int MW           = $clog2(MEM_DEPTH);
  localparam int GAIN_SHIFT   = 10;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_SAMPLE = 2'd1,
    FN_LEN    = 2'd2,
    FN_PRESET = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_AD = 2'd0,
    PH_SU = 2'd1,
    PH_RE = 2'd2,
    PH_XX = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_SCALE,
    ST_SUM,
    ST_SHIFT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        keys;
    logic [10:0]        pressure_gain;
    logic [3:0]         voice;
    logic [1:0]         segment;
    logic [12:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic [13:0]        segment_len;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mix_out;
    logic               clipped;
  } out_item_t;

endpackage

// ----- src/sample_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// sample_voice_mixer
// Sixteen-voice sample player with attack, sustain loop and release tables.
// ----------------------------------------------------------------------------
// channel  direction  payload           handshake
// in       input      svm_pkg::in_item_t  in_valid / in_ready
// out      output     svm_pkg::out_item_t out_valid / out_ready
// A load or preset transaction gives no result.
// A tick makes one sample-memory read per voice over the single read port,
// then scale, sum, shift and saturate steps.
// The sample memory has no reset; lengths and voice state clear at reset.
// A waiting result holds in the output register; the next item is taken
// once it has left.
module sample_voice_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  svm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output svm_pkg::out_item_t out_data
);

  localparam int CW = svm_pkg::VW + 1;

  logic [15:0] smem [svm_pkg::MEM_DEPTH];
  logic [15:0] rd_q;

  svm_pkg::state_t state_r, state_nxt;
  // three segment lengths per voice
  logic [svm_pkg::SEGS-1:0][svm_pkg::LW-1:0] seg_len_r [svm_pkg::VOICES];
  svm_pkg::phase_t        phase_r [svm_pkg::VOICES];
  logic [svm_pkg::AW-1:0] pos_r [svm_pkg::VOICES];
  logic [svm_pkg::VOICES-1:0] down_r;
  logic [10:0]            rgain_r [svm_pkg::VOICES];

  logic [15:0] keys_r;
  logic [10:0] gain_r;
  logic [CW-1:0] cnt_r;
  // per-voice info for the read in flight
  logic          pend_r;
  logic          pend_rel_r;
  logic          pend_ok_r;
  logic [10:0]   pend_g_r;
  logic signed [20:0] held_r;
  logic signed [31:0] rel_r;
  logic signed [31:0] hprod_r;
  logic signed [33:0] acc_r;
  logic signed [23:0] sh_r;
  logic        ovalid_r;
  svm_pkg::out_item_t odata_r;

  assign in_ready  = (state_r == svm_pkg::ST_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  logic acc_in;
  assign acc_in = in_valid && in_ready;

  // current voice decode
  logic [svm_pkg::VW-1:0] cv;
  logic on, rel_edge, active, is_rel;
  svm_pkg::phase_t ph_eff, ph_new;
  logic [svm_pkg::AW-1:0] pos_eff;
  logic [1:0] seg_sel;
  logic [svm_pkg::LW-1:0] len_c;
  logic [svm_pkg::LW-1:0] pos_inc;
  logic [10:0] rg_eff;
  logic [svm_pkg::MW-1:0] raddr;

  always_comb begin
    cv       = cnt_r[svm_pkg::VW-1:0];
    on       = keys_r[cv];
    rel_edge = down_r[cv] && !on;
    ph_eff   = rel_edge ? svm_pkg::PH_RE : phase_r[cv];
    pos_eff  = rel_edge ? '0 : pos_r[cv];
    rg_eff   = rel_edge ? gain_r : rgain_r[cv];
    is_rel   = 1'b0;
    active   = 1'b1;
    if (on) begin
      if (ph_eff != svm_pkg::PH_SU) begin
        if (ph_eff != svm_pkg::PH_AD) pos_eff = '0;
        ph_eff = svm_pkg::PH_AD;
      end
    end else if (ph_eff == svm_pkg::PH_RE) begin
      is_rel = 1'b1;
    end else begin
      active = 1'b0;
    end
    seg_sel = ph_eff;
    len_c   = seg_len_r[cv][seg_sel];
    pos_inc = {1'b0, pos_eff} + 1'b1;
    ph_new  = ph_eff;
    if (pos_inc >= len_c) begin
      if (ph_eff == svm_pkg::PH_AD) ph_new = svm_pkg::PH_SU;
      else if (ph_eff == svm_pkg::PH_RE) ph_new = svm_pkg::PH_AD;
    end
    raddr = svm_pkg::MW'(((cv * svm_pkg::SEGS) + seg_sel) * svm_pkg::SAMPLE_DEPTH)
            + svm_pkg::MW'(pos_eff);
  end

  logic rd_go;
  assign rd_go = (state_r == svm_pkg::ST_READ) && (cnt_r < CW'(svm_pkg::VOICES));

  logic wr_ok;
  assign wr_ok = acc_in && (in_data.func == svm_pkg::FN_SAMPLE)
                 && (32'(in_data.voice) < svm_pkg::VOICES)
                 && (in_data.segment < 2'(svm_pkg::SEGS))
                 && (32'(in_data.sample_addr) < svm_pkg::SAMPLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_ok)
      smem[svm_pkg::MW'(((32'(in_data.voice) * svm_pkg::SEGS) + 32'(in_data.segment))
           * svm_pkg::SAMPLE_DEPTH) + svm_pkg::MW'(in_data.sample_addr)]
        <= in_data.sample_value;
    if (rd_go && active) rd_q <= smem[raddr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svm_pkg::ST_IDLE: if (acc_in && in_data.func == svm_pkg::FN_TICK)
                          state_nxt = svm_pkg::ST_READ;
      svm_pkg::ST_READ: if (!rd_go) state_nxt = svm_pkg::ST_ACCUM;
      svm_pkg::ST_ACCUM: state_nxt = svm_pkg::ST_SCALE;
      svm_pkg::ST_SCALE: state_nxt = svm_pkg::ST_SUM;
      svm_pkg::ST_SUM:   state_nxt = svm_pkg::ST_SHIFT;
      svm_pkg::ST_SHIFT: state_nxt = svm_pkg::ST_OUT;
      svm_pkg::ST_OUT:   state_nxt = svm_pkg::ST_IDLE;
      default:           state_nxt = svm_pkg::ST_IDLE;
    endcase
  end

  logic signed [15:0] samp;
  logic signed [27:0] rprod;
  assign samp  = pend_ok_r ? $signed(rd_q) : 16'sd0;
  assign rprod = samp * $signed({1'b0, pend_g_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= svm_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
      down_r   <= '0;
      for (int i = 0; i < svm_pkg::VOICES; i++) begin
        phase_r[i]   <= svm_pkg::PH_AD;
        pos_r[i]     <= '0;
        rgain_r[i]   <= '0;
        seg_len_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      if (acc_in) begin
        unique case (in_data.func)
          svm_pkg::FN_TICK: begin
            keys_r <= in_data.keys;
            gain_r <= in_data.pressure_gain;
            cnt_r  <= '0;
            held_r <= '0;
            rel_r  <= '0;
          end
          svm_pkg::FN_LEN:
            if (32'(in_data.voice) < svm_pkg::VOICES && in_data.segment < 2'(svm_pkg::SEGS))
              seg_len_r[in_data.voice][in_data.segment] <=
                (32'(in_data.segment_len) > svm_pkg::SAMPLE_DEPTH) ?
                svm_pkg::LW'(svm_pkg::SAMPLE_DEPTH) : svm_pkg::LW'(in_data.segment_len);
          svm_pkg::FN_PRESET: down_r <= in_data.keys[svm_pkg::VOICES-1:0];
          default: ;
        endcase
      end
      // accumulate the sample read last cycle
      if (pend_r) begin
        if (pend_rel_r) rel_r <= rel_r + 32'(rprod);
        else held_r <= held_r + 21'(samp);
      end
      pend_r <= rd_go && active;
      if (rd_go) begin
        cnt_r      <= cnt_r + 1'b1;
        down_r[cv] <= on;
        pend_rel_r <= is_rel;
        pend_g_r   <= rg_eff;
        pend_ok_r  <= {1'b0, pos_eff} < len_c;
        if (rel_edge) rgain_r[cv] <= gain_r;
        if (active) begin
          phase_r[cv] <= ph_new;
          pos_r[cv]   <= (pos_inc >= len_c) ? '0 : pos_inc[svm_pkg::AW-1:0];
        end
      end
      if (state_r == svm_pkg::ST_SCALE) hprod_r <= held_r * $signed({1'b0, gain_r});
      if (state_r == svm_pkg::ST_SUM) acc_r <= 34'(hprod_r) + 34'(rel_r);
      if (state_r == svm_pkg::ST_SHIFT) sh_r <= 24'(acc_r >>> svm_pkg::GAIN_SHIFT);
      if (state_r == svm_pkg::ST_OUT) begin
        ovalid_r <= 1'b1;
        if (sh_r > 24'sd32767) begin
          odata_r.mix_out <= 16'sd32767;
          odata_r.clipped <= 1'b1;
        end else if (sh_r < -24'sd32768) begin
          odata_r.mix_out <= -16'sd32768;
          odata_r.clipped <= 1'b1;
        end else begin
          odata_r.mix_out <= sh_r[15:0];
          odata_r.clipped <= 1'b0;
        end
      end
    end
  end

  // a result only appears at the end of a tick
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == svm_pkg::ST_OUT)
    else $error("result without tick");
  // no input taken while a tick runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != svm_pkg::ST_IDLE) |-> !in_ready)
    else $error("input taken mid tick");
  // clip flag matches saturated values
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && odata_r.clipped) |->
      (odata_r.mix_out == 16'sd32767 || odata_r.mix_out == -16'sd32768))
    else $error("clip flag inconsistent");

endmodule

// ----- tb/sv/sample_voice_mixer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_voice_mixer_tb
// Drives load, preset and tick transactions into the voice mixer and checks
// every mixed sample against a behavioral predictor of the voice engine.
// ----------------------------------------------------------------------------
module sample_voice_mixer_tb;

  localparam int SMALL_LEN = 8;
  localparam int LIMIT     = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  svm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  svm_pkg::out_item_t out_data;

  sample_voice_mixer u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state; sample words kept sparse
  logic signed [15:0] pm_samples [int];
  int unsigned pm_len [svm_pkg::VOICES*svm_pkg::SEGS];
  svm_pkg::phase_t pm_phase [svm_pkg::VOICES];
  int unsigned pm_pos [svm_pkg::VOICES];
  logic pm_down [svm_pkg::VOICES];
  int unsigned pm_rgain [svm_pkg::VOICES];

  svm_pkg::in_item_t pending_items[$];
  svm_pkg::out_item_t expected_mix[$];
  int errors = 0;
  int ticks_checked = 0;
  int cycles = 0;
  int send_idle = 17;
  int recv_idle = 83;
  int n_loads = 0, n_presets = 0;
  bit hold_off = 0;

  function automatic int sidx(int v, int s, int a);
    return (v * svm_pkg::SEGS + s) * svm_pkg::SAMPLE_DEPTH + a;
  endfunction

  function automatic longint play_voice(int v, int s);
    longint smp = 0;
    int unsigned len = pm_len[v*svm_pkg::SEGS+s];
    if (pm_pos[v] < len && pm_pos[v] < svm_pkg::SAMPLE_DEPTH) begin
      if (pm_samples.exists(sidx(v, s, pm_pos[v]))) smp = pm_samples[sidx(v, s, pm_pos[v])];
    end
    pm_pos[v]++;
    if (pm_pos[v] >= len) begin
      pm_pos[v] = 0;
      if (s == svm_pkg::PH_AD) pm_phase[v] = svm_pkg::PH_SU;
      else if (s == svm_pkg::PH_RE) pm_phase[v] = svm_pkg::PH_AD;
    end
    return smp;
  endfunction

  task automatic predict_mix(svm_pkg::in_item_t it);
    longint held, rel, acc;
    svm_pkg::out_item_t r;
    logic on;
    held = 0;
    rel = 0;
    case (svm_pkg::func_t'(it.func))
      svm_pkg::FN_SAMPLE: begin
        if (it.segment < svm_pkg::SEGS)
          pm_samples[sidx(it.voice, it.segment, it.sample_addr)] = it.sample_value;
      end
      svm_pkg::FN_LEN: begin
        if (it.segment < svm_pkg::SEGS)
          pm_len[it.voice*svm_pkg::SEGS+it.segment] =
              (it.segment_len > svm_pkg::SAMPLE_DEPTH) ? svm_pkg::SAMPLE_DEPTH :
              32'(it.segment_len);
      end
      svm_pkg::FN_PRESET: begin
        for (int v = 0; v < svm_pkg::VOICES; v++) pm_down[v] = it.keys[v];
      end
      default: begin
        for (int v = 0; v < svm_pkg::VOICES; v++) begin
          on = it.keys[v];
          if (pm_down[v] && !on) begin
            pm_phase[v] = svm_pkg::PH_RE;
            pm_pos[v] = 0;
            pm_rgain[v] = 32'(it.pressure_gain);
          end
          if (on) begin
            if (pm_phase[v] == svm_pkg::PH_SU) held += play_voice(v, svm_pkg::PH_SU);
            else begin
              if (pm_phase[v] != svm_pkg::PH_AD) begin
                pm_phase[v] = svm_pkg::PH_AD;
                pm_pos[v] = 0;
              end
              held += play_voice(v, svm_pkg::PH_AD);
            end
          end else if (pm_phase[v] == svm_pkg::PH_RE) begin
            rel += play_voice(v, svm_pkg::PH_RE) * longint'(pm_rgain[v]);
          end
          pm_down[v] = on;
        end
        acc = (held * longint'(it.pressure_gain) + rel) >>> svm_pkg::GAIN_SHIFT;
        r.clipped = 1'b1;
        if (acc > 32767) r.mix_out = 16'sh7fff;
        else if (acc < -32768) r.mix_out = 16'sh8000;
        else begin
          r.mix_out = acc[15:0];
          r.clipped = 1'b0;
        end
        expected_mix.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at tick %0d: %s got %0d expected %0d", ticks_checked, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_mix(in_data);
        void'(pending_items.pop_front());
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_items.size() > 0 && !(hold_off && expected_mix.size() != 0) &&
            $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_mix.size() == 0) begin
          $display("result with nothing expected");
          errors++;
        end else begin
          svm_pkg::out_item_t e;
          e = expected_mix.pop_front();
          if (out_data.mix_out !== e.mix_out)
            report_mismatch("mix_out", out_data.mix_out, e.mix_out);
          if (out_data.clipped !== e.clipped)
            report_mismatch("clipped", out_data.clipped, e.clipped);
        end
        ticks_checked++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic svm_pkg::in_item_t mk(svm_pkg::func_t f);
    svm_pkg::in_item_t it;
    it = '0;
    it.func = f;
    it.keys = 16'($urandom);
    it.pressure_gain = 11'($urandom);
    it.voice = 4'($urandom);
    it.segment = 2'($urandom_range(2));
    it.sample_addr = 13'($urandom_range(SMALL_LEN - 1));
    it.sample_value = 16'($urandom);
    it.segment_len = 14'($urandom_range(SMALL_LEN));
    return it;
  endfunction

  task automatic add_item(svm_pkg::in_item_t it);
    if (it.func == svm_pkg::FN_TICK) n_loads = n_loads;
    else n_loads++;
    if (it.func == svm_pkg::FN_PRESET) n_presets++;
    pending_items.push_back(it);
  endtask

  task automatic wait_drain();
    while (pending_items.size() != 0 || in_valid || expected_mix.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // fill every table word below the segment's reach so no unwritten read occurs
  task automatic load_tables(int maxlen, bit extreme);
    svm_pkg::in_item_t it;
    for (int v = 0; v < svm_pkg::VOICES; v++)
      for (int s = 0; s < svm_pkg::SEGS; s++) begin
        for (int a = 0; a < maxlen; a++) begin
          it = mk(svm_pkg::FN_SAMPLE);
          it.voice = 4'(v);
          it.segment = 2'(s);
          it.sample_addr = 13'(a);
          if (extreme) it.sample_value = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
          add_item(it);
        end
        it = mk(svm_pkg::FN_LEN);
        it.voice = 4'(v);
        it.segment = 2'(s);
        it.segment_len = 14'($urandom_range(maxlen));
        add_item(it);
      end
  endtask

  task automatic random_ticks(int n);
    svm_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: add_item(mk(svm_pkg::FN_PRESET));
        1: begin
          it = mk(svm_pkg::FN_SAMPLE);
          if ($urandom_range(1)) it.segment = 2'd3;
          else it.sample_addr = 13'($urandom_range(8191));
          if (it.segment != 2'd3 && it.sample_addr >= SMALL_LEN) it.sample_addr[12] = 1'b1;
          add_item(it);
        end
        2: begin
          it = mk(svm_pkg::FN_LEN);
          if ($urandom_range(3) == 0) it.segment = 2'd3;
          add_item(it);
        end
        default: begin
          it = mk(svm_pkg::FN_TICK);
          if ($urandom_range(3) == 0) it.keys = it.keys & 16'h000f;
          add_item(it);
        end
      endcase
    end
  endtask

  initial begin
    svm_pkg::in_item_t it;
    for (int i = 0; i < svm_pkg::VOICES*svm_pkg::SEGS; i++) pm_len[i] = 0;
    for (int v = 0; v < svm_pkg::VOICES; v++) begin
      pm_phase[v] = svm_pkg::PH_AD;
      pm_pos[v] = 0;
      pm_down[v] = 1'b0;
      pm_rgain[v] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty segments, long lengths, then full-scale tables with short lengths
    it = mk(svm_pkg::FN_TICK); it.keys = 16'hffff; it.pressure_gain = 11'h7ff; add_item(it);
    it = mk(svm_pkg::FN_TICK); it.keys = 16'h0000; add_item(it);
    it = mk(svm_pkg::FN_LEN); it.segment_len = 14'h3fff; it.segment = 2'd0; add_item(it);
    it = mk(svm_pkg::FN_LEN); it.segment_len = 14'h2000; it.segment = 2'd3; add_item(it);
    it = mk(svm_pkg::FN_SAMPLE); it.segment = 2'd3; add_item(it);
    it = mk(svm_pkg::FN_SAMPLE); it.segment = 2'd0; it.sample_addr = 13'h1fff;
    it.sample_value = 16'sh7fff; add_item(it);
    it = mk(svm_pkg::FN_PRESET); it.keys = 16'hffff; add_item(it);
    it = mk(svm_pkg::FN_TICK); it.keys = 16'h0000; it.pressure_gain = '0; add_item(it);
    it = mk(svm_pkg::FN_LEN); it.segment = 2'd0; it.segment_len = '0; add_item(it);
    load_tables(SMALL_LEN, 1'b1);
    for (int i = 0; i < 6; i++) begin
      it = mk(svm_pkg::FN_TICK); it.keys = 16'hffff; it.pressure_gain = 11'h7ff;
      add_item(it);
    end
    it = mk(svm_pkg::FN_TICK); it.keys = 16'h5555; it.pressure_gain = 11'h7ff; add_item(it);
    it = mk(svm_pkg::FN_TICK); it.keys = 16'haaaa; it.pressure_gain = 11'd1; add_item(it);
    it = mk(svm_pkg::FN_TICK); it.keys = 16'hffff; add_item(it);
    wait_drain();

    // sender pauses after each tick until its result is out
    hold_off = 1;
    random_ticks(60);
    wait_drain();
    hold_off = 0;

    random_ticks(200);
    wait_drain();
    send_idle = 83;
    recv_idle = 17;
    load_tables(4, 1'b0);
    random_ticks(200);
    wait_drain();
    send_idle = 0;
    recv_idle = 0;
    random_ticks(200);
    wait_drain();

    $display("checked %0d mixed samples, %0d load and preset transactions (%0d presets)",
             ticks_checked, n_loads, n_presets);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ----- sim.f -----
src/svm_pkg.sv
src/sample_voice_mixer.sv
tb/sv/sample_voice_mixer_tb.sv
